### hw/rtl/lru_page_replacement_top_macros.svh
// Assertion macros shared by the LRU page replacement RTL.
// Depends on a clock named clock and an active-high reset named reset in the using module.
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("LRU page replacement: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRUP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("LRU page replacement: next-cycle check failed");

`endif

### hw/rtl/lrup_pkg.sv
// Shared constants and helper functions for the LRU page replacement block.
// No dependencies.
package lrup_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int NUM_PAGES_DEF   = 1024;

   localparam int PAGE_IN_W  = 10;
   localparam int CFG_W      = 5;
   localparam int HIT_CNT_W  = 32;

   localparam logic [CFG_W-1:0] FRAME_LIMIT_RESET = 5'd16;

   // Reduces a page number modulo num_pages by conditional subtraction of
   // shifted copies of the modulus, most significant first.
   function automatic logic [PAGE_IN_W-1:0] wrap_page(input logic [PAGE_IN_W-1:0] page,
                                                       input int num_pages);
      int rem;
      int step;
      rem = int'(page);
      if (num_pages < (1 << PAGE_IN_W)) begin
         for (int k = PAGE_IN_W - 1; k >= 0; k--) begin
            step = num_pages << k;
            if ((step < (1 << PAGE_IN_W)) && (rem >= step)) begin
               rem = rem - step;
            end
         end
      end
      return PAGE_IN_W'(rem);
   endfunction

endpackage

### hw/rtl/lru_page_replacement_top.sv
// Top level of the fully associative LRU page replacement tracker.
// Depends on lrup_pkg and lru_page_replacement_top_macros.svh.

// One page reference is taken per clock cycle while req_stall is low, and
// each reference produces exactly one result: the reference is wrapped into
// the page range and captured in an input register, then all frames are
// compared in parallel, the recency ranks are updated and the result is
// captured in an output register. The one-per-cycle rate is set by doing the
// tag compare and rank update combinationally over the frames held in
// flip-flops. A stalled result holds the output register, and the input
// register then holds its reference. Frame valid bits clear at reset, so no
// clearing pass is needed. The user must write the frame limit register only
// while the block is idle; the block itself does not enforce this. Values of
// 0 act as 1 and values above MAX_ENTRIES act as MAX_ENTRIES.
module lru_page_replacement_top #(
   parameter int MAX_ENTRIES = lrup_pkg::MAX_ENTRIES_DEF,
   parameter int NUM_PAGES   = lrup_pkg::NUM_PAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lrup_pkg::PAGE_IN_W-1:0]  req_page,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_hit,
   output logic                            rsp_evicted_valid,
   output logic [lrup_pkg::PAGE_IN_W-1:0]  rsp_evicted_page,
   output logic [lrup_pkg::HIT_CNT_W-1:0]  rsp_hits_so_far,

   input  logic                            csr_write_enable,
   input  logic [lrup_pkg::CFG_W-1:0]      csr_write_data
);

`include "lru_page_replacement_top_macros.svh"

   localparam int PAGE_FULL_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int PAGE_W = (PAGE_FULL_W < lrup_pkg::PAGE_IN_W) ? PAGE_FULL_W
                                                                : lrup_pkg::PAGE_IN_W;
   localparam int AGE_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > lrup_pkg::CFG_W) ? OCC_W : lrup_pkg::CFG_W;

   localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(MAX_ENTRIES);

   // Configuration.
   logic [lrup_pkg::CFG_W-1:0] frame_limit_ff, frame_limit_in;

   // Input register.
   logic              req_valid_ff, req_valid_in;
   logic [PAGE_W-1:0] req_page_ff, req_page_in;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic                           rsp_evicted_valid_ff, rsp_evicted_valid_in;
   logic [lrup_pkg::PAGE_IN_W-1:0] rsp_evicted_page_ff, rsp_evicted_page_in;

   // Cache state.
   logic [PAGE_W-1:0]              frame_page_ff [MAX_ENTRIES];
   logic [PAGE_W-1:0]              frame_page_in [MAX_ENTRIES];
   logic [AGE_W-1:0]               frame_age_ff  [MAX_ENTRIES];
   logic [AGE_W-1:0]               frame_age_in  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]         frame_valid_ff, frame_valid_in;
   logic [OCC_W-1:0]               occupancy_ff, occupancy_in;
   logic [lrup_pkg::HIT_CNT_W-1:0] hit_total_ff, hit_total_in;

   // Lookup.
   logic                           advance;
   logic [MAX_ENTRIES-1:0]         match_vec;
   logic [MAX_ENTRIES-1:0]         victim_vec;
   logic [MAX_ENTRIES-1:0]         free_vec;
   logic [MAX_ENTRIES-1:0]         slot_vec;
   logic                           is_hit;
   logic                           is_full;
   logic [AGE_W-1:0]               hit_age;
   logic [AGE_W-1:0]               oldest_age;
   logic [PAGE_W-1:0]              victim_page;
   logic [CMP_W-1:0]               capacity;
   logic [lrup_pkg::PAGE_IN_W-1:0] wrapped_page;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   assign wrapped_page = lrup_pkg::wrap_page(req_page, NUM_PAGES);

   always_comb begin
      req_valid_in = req_valid_ff;
      req_page_in  = req_page_ff;
      if (advance) begin
         req_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         req_valid_in = 1'b1;
         req_page_in  = PAGE_W'(wrapped_page);
      end
   end

   always_comb begin
      frame_limit_in = frame_limit_ff;
      if (csr_write_enable) begin
         frame_limit_in = csr_write_data;
      end
   end

   always_comb begin
      if (frame_limit_ff == '0) begin
         capacity = CMP_W'(1);
      end else if (CMP_W'(frame_limit_ff) > CAP_MAX) begin
         capacity = CAP_MAX;
      end else begin
         capacity = CMP_W'(frame_limit_ff);
      end
   end

   assign is_full = CMP_W'(occupancy_ff) >= capacity;

   // Valid ranks form a permutation of 0 to occupancy minus one, so the least
   // recent frame is the one whose rank equals occupancy minus one.
   assign oldest_age = AGE_W'(occupancy_ff - OCC_W'(1));

   always_comb begin
      hit_age     = '0;
      victim_page = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_vec[i]  = frame_valid_ff[i] && (frame_page_ff[i] == req_page_ff);
         victim_vec[i] = frame_valid_ff[i] && (frame_age_ff[i] == oldest_age);
         hit_age       = hit_age | (match_vec[i] ? frame_age_ff[i] : '0);
         victim_page   = victim_page | (victim_vec[i] ? frame_page_ff[i] : '0);
      end
   end

   assign is_hit   = |match_vec;
   // Lowest free frame.
   assign free_vec = ~frame_valid_ff & (frame_valid_ff + MAX_ENTRIES'(1));
   assign slot_vec = is_full ? victim_vec : free_vec;

   always_comb begin
      frame_page_in  = frame_page_ff;
      frame_age_in   = frame_age_ff;
      frame_valid_in = frame_valid_ff;
      occupancy_in   = occupancy_ff;
      hit_total_in   = hit_total_ff;
      if (advance) begin
         if (is_hit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (match_vec[i]) begin
                  frame_age_in[i] = '0;
               end else if (frame_valid_ff[i] && (frame_age_ff[i] < hit_age)) begin
                  frame_age_in[i] = frame_age_ff[i] + AGE_W'(1);
               end
            end
            if (hit_total_ff != '1) begin
               hit_total_in = hit_total_ff + lrup_pkg::HIT_CNT_W'(1);
            end
         end else begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (slot_vec[i]) begin
                  frame_page_in[i]  = req_page_ff;
                  frame_age_in[i]   = '0;
                  frame_valid_in[i] = 1'b1;
               end else if (frame_valid_ff[i]) begin
                  frame_age_in[i] = frame_age_ff[i] + AGE_W'(1);
               end
            end
            if (!is_full) begin
               occupancy_in = occupancy_ff + OCC_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in         = rsp_valid_ff;
      rsp_hit_in           = rsp_hit_ff;
      rsp_evicted_valid_in = rsp_evicted_valid_ff;
      rsp_evicted_page_in  = rsp_evicted_page_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in         = 1'b1;
         rsp_hit_in           = is_hit;
         rsp_evicted_valid_in = !is_hit && is_full;
         rsp_evicted_page_in  = (!is_hit && is_full) ?
                                lrup_pkg::PAGE_IN_W'(victim_page) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= lrup_pkg::FRAME_LIMIT_RESET;
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         frame_valid_ff <= '0;
         occupancy_ff   <= '0;
         hit_total_ff   <= '0;
      end else begin
         frame_limit_ff <= frame_limit_in;
         req_valid_ff   <= req_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_valid_ff <= frame_valid_in;
         occupancy_ff   <= occupancy_in;
         hit_total_ff   <= hit_total_in;
      end
   end

   always_ff @(posedge clock) begin
      req_page_ff          <= req_page_in;
      rsp_hit_ff           <= rsp_hit_in;
      rsp_evicted_valid_ff <= rsp_evicted_valid_in;
      rsp_evicted_page_ff  <= rsp_evicted_page_in;
      frame_page_ff        <= frame_page_in;
      frame_age_ff         <= frame_age_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   // The running count is only updated together with a result transfer into
   // the output register, so it always matches the result on display.
   assign rsp_hits_so_far   = hit_total_ff;

   `LRUP_ASSERT_NOW(a_occupancy_matches_valid, 1'b1,
                    $countones(frame_valid_ff) == int'(occupancy_ff))
   `LRUP_ASSERT_NOW(a_hit_never_evicts, rsp_valid_ff, !(rsp_hit_ff && rsp_evicted_valid_ff))
   `LRUP_ASSERT_NOW(a_one_slot_on_miss, advance && !is_hit, $onehot(slot_vec))
   `LRUP_ASSERT_NOW(a_hit_count_nonzero, rsp_valid_ff && rsp_hit_ff, hit_total_ff != '0)
   `LRUP_ASSERT_NEXT(a_fill_grows_occupancy, advance && !is_hit && !is_full,
                     occupancy_ff == $past(occupancy_ff) + OCC_W'(1))

endmodule

### test/tb.sv
// Self-checking testbench for the fully associative LRU page replacement block.
// Depends on lrup_pkg and lru_page_replacement_top. A built-in recency model predicts
// every result.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW      = lrup_pkg::PAGE_IN_W;
   localparam int CW      = lrup_pkg::CFG_W;
   localparam int HW      = lrup_pkg::HIT_CNT_W;
   localparam int FRAMES  = lrup_pkg::MAX_ENTRIES_DEF;
   localparam int PAGES   = lrup_pkg::NUM_PAGES_DEF;
   localparam int MAX_GAP = 7;

   typedef struct packed {
      logic          hit;
      logic          ev_valid;
      logic [PW-1:0] ev_page;
      logic [HW-1:0] hits;
   } lookup_result_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [PW-1:0] req_page;
   logic          rsp_valid;
   logic          rsp_stall;
   logic          rsp_hit;
   logic          rsp_evicted_valid;
   logic [PW-1:0] rsp_evicted_page;
   logic [HW-1:0] rsp_hits_so_far;
   logic          csr_write_enable;
   logic [CW-1:0] csr_write_data;

   // Recency model of the cache frames.
   logic [PW-1:0] frame_tag [FRAMES];
   logic          frame_used [FRAMES];
   logic [7:0]    frame_rank [FRAMES];
   int unsigned   frames_held;
   logic [HW-1:0] hit_tally;
   logic [CW-1:0] capacity_reg;

   lookup_result_type pending_lookups [$];
   int unsigned       mismatch_count;
   bit                no_idle;
   int unsigned       hold_off_cycles;

   lru_page_replacement_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hits_so_far   (rsp_hits_so_far),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic lookup_result_type predict_lookup(input logic [PW-1:0] raw);
      lookup_result_type r;
      int unsigned pg;
      int unsigned cap;
      int match;
      int victim;
      logic [7:0] rank;
      logic [7:0] oldest;
      r = '0;
      pg = int'(raw) % PAGES;
      cap = int'(capacity_reg);
      if (cap < 1) cap = 1;
      if (cap > FRAMES) cap = FRAMES;
      match = -1;
      victim = -1;
      oldest = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (match < 0 && frame_used[i] && frame_tag[i] == PW'(pg)) match = i;
      end
      if (match >= 0) begin
         rank = frame_rank[match];
         for (int i = 0; i < FRAMES; i++) begin
            if (frame_used[i] && frame_rank[i] < rank) frame_rank[i] = frame_rank[i] + 8'd1;
         end
         frame_rank[match] = '0;
         if (hit_tally != '1) hit_tally = hit_tally + 1'b1;
         r.hit = 1'b1;
      end else begin
         // A full cache gives up its least recent frame before the new page goes in.
         if (frames_held >= cap) begin
            for (int i = 0; i < FRAMES; i++) begin
               if (frame_used[i] && (victim < 0 || frame_rank[i] > oldest)) begin
                  victim = i;
                  oldest = frame_rank[i];
               end
            end
            if (victim >= 0) begin
               r.ev_valid = 1'b1;
               r.ev_page = frame_tag[victim];
               frame_used[victim] = 1'b0;
            end
         end
         if (victim < 0) begin
            for (int i = 0; i < FRAMES; i++) begin
               if (victim < 0 && !frame_used[i]) victim = i;
            end
            if (victim >= 0) frames_held++;
         end
         for (int i = 0; i < FRAMES; i++) begin
            if (frame_used[i] && frame_rank[i] < 8'd255) frame_rank[i] = frame_rank[i] + 8'd1;
         end
         if (victim >= 0) begin
            frame_tag[victim] = PW'(pg);
            frame_used[victim] = 1'b1;
            frame_rank[victim] = '0;
         end
      end
      r.hits = hit_tally;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [HW-1:0] got,
                                  input logic [HW-1:0] want);
      if (mismatch_count < 50)
         $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Offers one reference and records the predicted result once the transfer happens.
   task automatic send_page(input logic [PW-1:0] page);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page  <= page;
      do @(posedge clock); while (req_stall);
      pending_lookups.push_back(predict_lookup(page));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CW-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_reg = value;
   endtask

   // Mostly references from a small working set so that hits and evictions both occur.
   function automatic logic [PW-1:0] draw_page(input int unsigned base, input int unsigned span);
      if ($urandom_range(0, 9) < 8) return PW'(base + $urandom_range(0, span - 1));
      return PW'($urandom_range(0, PAGES - 1));
   endfunction

   task automatic test_fill_and_hit();
      send_page(PW'(0));
      send_page(PW'(PAGES - 1));
      send_page(PW'(0));
      send_page(PW'(PAGES - 1));
      send_page(PW'(10'h155));
      send_page(PW'(10'h2AA));
      send_page(PW'(10'h155));
   endtask

   task automatic test_single_frame();
      set_capacity(CW'(1));
      send_page(PW'(7));
      send_page(PW'(7));
      send_page(PW'(8));
      // A capacity of zero behaves as a single frame.
      set_capacity(CW'(0));
      send_page(PW'(9));
      send_page(PW'(9));
      // Values above the frame count behave as the full frame count.
      set_capacity(CW'(31));
      send_page(PW'(10));
      send_page(PW'(11));
   endtask

   task automatic test_shrink_below_occupancy();
      set_capacity(CW'(16));
      for (int i = 0; i < 5; i++) send_page(PW'(100 + i));
      set_capacity(CW'(2));
      send_page(PW'(200));
      send_page(PW'(103));
      send_page(PW'(201));
      send_page(PW'(200));
   endtask

   task automatic test_random_capacities();
      logic [CW-1:0] caps [11];
      int unsigned base;
      caps = '{CW'(1), CW'(2), CW'(3), CW'(4), CW'(8), CW'(15), CW'(16), CW'(0), CW'(31),
               CW'(17), CW'($urandom_range(0, 31))};
      foreach (caps[k]) begin
         set_capacity(caps[k]);
         no_idle = ($urandom_range(0, 3) == 0);
         base = $urandom_range(0, PAGES - 1);
         for (int n = 0; n < 105; n++) begin
            if ($urandom_range(0, 39) == 0) base = $urandom_range(0, PAGES - 1);
            send_page(draw_page(base, (caps[k] > FRAMES ? FRAMES : caps[k]) + 4));
         end
         no_idle = 1'b0;
      end
   endtask

   task automatic test_streaming();
      int unsigned base;
      set_capacity(CW'(8));
      no_idle = 1'b1;
      base = $urandom_range(0, PAGES - 1);
      for (int n = 0; n < 150; n++) send_page(draw_page(base, 12));
      no_idle = 1'b0;
   endtask

   task automatic test_output_backpressure();
      int unsigned base;
      wait_idle();
      base = $urandom_range(0, PAGES - 1);
      no_idle = 1'b1;
      hold_off_cycles = 80;
      for (int n = 0; n < 40; n++) send_page(draw_page(base, 20));
      no_idle = 1'b0;
   endtask

   task automatic test_sender_pause();
      int unsigned base;
      set_capacity(CW'(4));
      for (int b = 0; b < 4; b++) begin
         base = $urandom_range(0, PAGES - 1);
         for (int n = 0; n < 20; n++) send_page(draw_page(base, 7));
         wait_idle();
      end
   endtask

   // Receiver: random stall before each transfer, plus a requested long hold-off.
   initial begin
      int unsigned stall_len;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_stall <= 1'b0;
         end else begin
            stall_len = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid && hold_off_cycles == 0);
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("unexpected result, hit", HW'(rsp_hit), '0);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", HW'(rsp_hit), HW'(want.hit));
            if (rsp_evicted_valid !== want.ev_valid)
               report_mismatch("evicted_valid", HW'(rsp_evicted_valid), HW'(want.ev_valid));
            if (rsp_evicted_page !== want.ev_page)
               report_mismatch("evicted_page", HW'(rsp_evicted_page), HW'(want.ev_page));
            if (rsp_hits_so_far !== want.hits)
               report_mismatch("hits_so_far", rsp_hits_so_far, want.hits);
         end
      end
   end

   initial begin
      int unsigned drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_page = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      no_idle = 1'b0;
      hold_off_cycles = 0;
      mismatch_count = 0;
      frames_held = 0;
      hit_tally = '0;
      capacity_reg = lrup_pkg::FRAME_LIMIT_RESET;
      for (int i = 0; i < FRAMES; i++) begin
         frame_tag[i] = '0;
         frame_used[i] = 1'b0;
         frame_rank[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_hit();
      test_single_frame();
      test_shrink_below_occupancy();
      test_random_capacities();
      test_streaming();
      test_output_backpressure();
      test_sender_pause();

      req_valid <= 1'b0;
      drain = 0;
      while (pending_lookups.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      while (pending_lookups.size() != 0) begin
         void'(pending_lookups.pop_front());
         report_mismatch("missing result, count", '0, HW'(1));
      end
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lrup_pkg.sv
hw/rtl/lru_page_replacement_top.sv
test/tb.sv
